/* rtl/core/ggvc_pkg.sv */
// ============================================================================
// ggvc_pkg
// Shared types, widths, constants and the arctangent table for the
// go-to-goal velocity controller.
// ============================================================================
`timescale 1ns / 1ps

package ggvc_pkg;

    // CORDIC depth; the arctangent table holds 24 entries
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NUM_ITER      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                  : ATAN_ENTRIES;

    // field and datapath widths
    localparam int POS_W      = 16;
    localparam int ERR_W      = POS_W + 1;   // goal - pos
    localparam int SQ_W       = 32;          // dx*dx, tol*tol
    localparam int VEC_W      = 35;          // CORDIC x/y, error << 14 plus gain growth
    localparam int ROT_ZW     = 33;          // rotation residual angle
    localparam int ANG_W      = 32;          // binary angle, 2^31 = pi
    localparam int GAIN_W     = 12;
    localparam int TOL_W      = 16;
    localparam int CMD_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the registers
    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST = 12'd512;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST   = 12'd512;
    localparam logic [TOL_W-1:0]  ARRIVAL_TOL_RST = 16'd3;

    // 1/K in Q30 and pi in Q29
    localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
    localparam logic signed [31:0] PI_Q29       = 32'sd1686629713;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINEAR_GAIN = 2'd0,
        CFG_TURN_GAIN   = 2'd1,
        CFG_ARRIVAL_TOL = 2'd2
    } t_cfg_idx;

    // control that travels with an item between pipeline sections
    typedef struct packed {
        logic valid;
        logic reached;
    } t_ctl;

    // one result item
    typedef struct packed {
        logic                    reached;
        logic signed [CMD_W-1:0] linear_speed;
        logic signed [CMD_W-1:0] turn_rate;
    } t_result;

    // atan(2^-i) as a binary angle, 2^31 = pi
    function automatic logic [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/ggvc_front.sv */
// ============================================================================
// ggvc_front
// Position error, arrival check and quadrant pre-rotation (three stages).
// ============================================================================
`timescale 1ns / 1ps

module ggvc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [ggvc_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [ggvc_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [ggvc_pkg::POS_W-1:0]    i_heading,
    input  logic signed [ggvc_pkg::POS_W-1:0]    i_goal_x,
    input  logic signed [ggvc_pkg::POS_W-1:0]    i_goal_y,
    input  logic        [ggvc_pkg::TOL_W-1:0]    i_tol,
    output ggvc_pkg::t_ctl                       o_ctl,
    output logic signed [ggvc_pkg::VEC_W-1:0]    o_x,
    output logic signed [ggvc_pkg::VEC_W-1:0]    o_y,
    output logic signed [ggvc_pkg::ROT_ZW-1:0]   o_z
);

    localparam logic signed [ggvc_pkg::ROT_ZW-1:0] QUARTER = 33'sd1073741824;
    localparam logic signed [ggvc_pkg::ROT_ZW-1:0] HALF    = 33'sd2147483648;

    // stage 1: error
    logic                                r_v1;
    logic signed [ggvc_pkg::ERR_W-1:0]   r_dx, r_dy;
    logic signed [ggvc_pkg::POS_W-1:0]   r_hd;
    // stage 2: squares, pre-rotated vector
    logic                                r_v2;
    logic        [ggvc_pkg::SQ_W-1:0]    r_dx2, r_dy2, r_tol2;
    logic signed [ggvc_pkg::VEC_W-1:0]   r_x2, r_y2;
    logic signed [ggvc_pkg::ROT_ZW-1:0]  r_z2;
    // stage 3: arrival flag
    logic                                r_v3, r_reached3;
    logic signed [ggvc_pkg::VEC_W-1:0]   r_x3, r_y3;
    logic signed [ggvc_pkg::ROT_ZW-1:0]  r_z3;

    logic signed [2*ggvc_pkg::ERR_W-1:0] dx_sq, dy_sq;
    logic signed [ggvc_pkg::VEC_W-1:0]   n_x2, n_y2, x0, y0;
    logic signed [ggvc_pkg::ROT_ZW-1:0]  n_z2, z0;
    logic        [ggvc_pkg::SQ_W:0]      dist2;

    assign dx_sq = r_dx * r_dx;
    assign dy_sq = r_dy * r_dy;

    // error scaled by 2^14, angle negated and scaled by 2^16
    always_comb begin
        x0 = $signed({{4{r_dx[ggvc_pkg::ERR_W-1]}}, r_dx, 14'b0});
        y0 = $signed({{4{r_dy[ggvc_pkg::ERR_W-1]}}, r_dy, 14'b0});
        z0 = -$signed({r_hd[ggvc_pkg::POS_W-1], r_hd, 16'b0});
        n_x2 = x0;
        n_y2 = y0;
        n_z2 = z0;
        // fold into +/- pi/2 by a half turn
        if (z0 > QUARTER) begin
            n_z2 = z0 - HALF;
            n_x2 = -x0;
            n_y2 = -y0;
        end else if (z0 < -QUARTER) begin
            n_z2 = z0 + HALF;
            n_x2 = -x0;
            n_y2 = -y0;
        end
    end

    assign dist2 = {1'b0, r_dx2} + {1'b0, r_dy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx       <= $signed({i_goal_x[ggvc_pkg::POS_W-1], i_goal_x})
                        - $signed({i_pos_x[ggvc_pkg::POS_W-1], i_pos_x});
            r_dy       <= $signed({i_goal_y[ggvc_pkg::POS_W-1], i_goal_y})
                        - $signed({i_pos_y[ggvc_pkg::POS_W-1], i_pos_y});
            r_hd       <= i_heading;
            r_dx2      <= dx_sq[ggvc_pkg::SQ_W-1:0];
            r_dy2      <= dy_sq[ggvc_pkg::SQ_W-1:0];
            r_tol2     <= i_tol * i_tol;
            r_x2       <= n_x2;
            r_y2       <= n_y2;
            r_z2       <= n_z2;
            r_reached3 <= dist2 <= {1'b0, r_tol2};
            r_x3       <= r_x2;
            r_y3       <= r_y2;
            r_z3       <= r_z2;
        end
    end

    assign o_ctl = '{valid: r_v3, reached: r_reached3};
    assign o_x   = r_x3;
    assign o_y   = r_y3;
    assign o_z   = r_z3;

endmodule

/* rtl/core/ggvc_rotate.sv */
// ============================================================================
// ggvc_rotate
// Rotation-mode CORDIC, one iteration per stage: turns the error vector into
// the body frame.
// ============================================================================
`timescale 1ns / 1ps

module ggvc_rotate (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  ggvc_pkg::t_ctl                       i_ctl,
    input  logic signed [ggvc_pkg::VEC_W-1:0]    i_x,
    input  logic signed [ggvc_pkg::VEC_W-1:0]    i_y,
    input  logic signed [ggvc_pkg::ROT_ZW-1:0]   i_z,
    output ggvc_pkg::t_ctl                       o_ctl,
    output logic signed [ggvc_pkg::VEC_W-1:0]    o_x,
    output logic signed [ggvc_pkg::VEC_W-1:0]    o_y
);

    localparam int N = ggvc_pkg::NUM_ITER;

    logic                               r_valid   [N];
    logic                               r_reached [N];
    logic signed [ggvc_pkg::VEC_W-1:0]  r_x       [N];
    logic signed [ggvc_pkg::VEC_W-1:0]  r_y       [N];
    logic signed [ggvc_pkg::ROT_ZW-1:0] r_z       [N];

    for (genvar k = 0; k < N; k++) begin : g_iter
        localparam logic signed [ggvc_pkg::ROT_ZW-1:0] ATAN_K =
            $signed({1'b0, ggvc_pkg::atan_entry(k)});

        logic                               a_v, a_r;
        logic signed [ggvc_pkg::VEC_W-1:0]  a_x, a_y, n_x, n_y;
        logic signed [ggvc_pkg::ROT_ZW-1:0] a_z, n_z;

        if (k == 0) begin : g_head
            assign a_v = i_ctl.valid;
            assign a_r = i_ctl.reached;
            assign a_x = i_x;
            assign a_y = i_y;
            assign a_z = i_z;
        end else begin : g_body
            assign a_v = r_valid[k-1];
            assign a_r = r_reached[k-1];
            assign a_x = r_x[k-1];
            assign a_y = r_y[k-1];
            assign a_z = r_z[k-1];
        end

        always_comb begin
            if (!a_z[ggvc_pkg::ROT_ZW-1]) begin
                n_x = a_x - (a_y >>> k);
                n_y = a_y + (a_x >>> k);
                n_z = a_z - ATAN_K;
            end else begin
                n_x = a_x + (a_y >>> k);
                n_y = a_y - (a_x >>> k);
                n_z = a_z + ATAN_K;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_reached[k] <= a_r;
                r_x[k]       <= n_x;
                r_y[k]       <= n_y;
                r_z[k]       <= n_z;
            end
        end
    end

    assign o_ctl = '{valid: r_valid[N-1], reached: r_reached[N-1]};
    assign o_x   = r_x[N-1];
    assign o_y   = r_y[N-1];

endmodule

/* rtl/core/ggvc_vector.sv */
// ============================================================================
// ggvc_vector
// Vectoring-mode CORDIC: angle of the body-frame error. Half-turn fold stage
// followed by one iteration per stage; the rotated x rides along.
// ============================================================================
`timescale 1ns / 1ps

module ggvc_vector (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  ggvc_pkg::t_ctl                       i_ctl,
    input  logic signed [ggvc_pkg::VEC_W-1:0]    i_x,
    input  logic signed [ggvc_pkg::VEC_W-1:0]    i_y,
    output ggvc_pkg::t_ctl                       o_ctl,
    output logic signed [ggvc_pkg::VEC_W-1:0]    o_x_rot,
    output logic        [ggvc_pkg::ANG_W-1:0]    o_ang
);

    localparam int N = ggvc_pkg::NUM_ITER;
    localparam logic [ggvc_pkg::ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    // fold stage
    logic                               r_pvalid, r_preached;
    logic signed [ggvc_pkg::VEC_W-1:0]  r_px, r_py, r_pxrot;
    logic        [ggvc_pkg::ANG_W-1:0]  r_pang;

    logic                               r_valid   [N];
    logic                               r_reached [N];
    logic signed [ggvc_pkg::VEC_W-1:0]  r_x       [N];
    logic signed [ggvc_pkg::VEC_W-1:0]  r_y       [N];
    logic signed [ggvc_pkg::VEC_W-1:0]  r_xrot    [N];
    logic        [ggvc_pkg::ANG_W-1:0]  r_ang     [N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else if (i_en) begin
            r_pvalid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_preached <= i_ctl.reached;
            r_pxrot    <= i_x;
            if (i_x[ggvc_pkg::VEC_W-1]) begin
                r_px   <= -i_x;
                r_py   <= -i_y;
                r_pang <= HALF_TURN;
            end else begin
                r_px   <= i_x;
                r_py   <= i_y;
                r_pang <= '0;
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        localparam logic [ggvc_pkg::ANG_W-1:0] ATAN_K = ggvc_pkg::atan_entry(k);

        logic                              a_v, a_r;
        logic signed [ggvc_pkg::VEC_W-1:0] a_x, a_y, a_xrot, n_x, n_y;
        logic        [ggvc_pkg::ANG_W-1:0] a_ang, n_ang;

        if (k == 0) begin : g_head
            assign a_v    = r_pvalid;
            assign a_r    = r_preached;
            assign a_x    = r_px;
            assign a_y    = r_py;
            assign a_xrot = r_pxrot;
            assign a_ang  = r_pang;
        end else begin : g_body
            assign a_v    = r_valid[k-1];
            assign a_r    = r_reached[k-1];
            assign a_x    = r_x[k-1];
            assign a_y    = r_y[k-1];
            assign a_xrot = r_xrot[k-1];
            assign a_ang  = r_ang[k-1];
        end

        // drive y toward zero, accumulate the angle (wraps mod 2^32)
        always_comb begin
            if (!a_y[ggvc_pkg::VEC_W-1]) begin
                n_x   = a_x + (a_y >>> k);
                n_y   = a_y - (a_x >>> k);
                n_ang = a_ang + ATAN_K;
            end else begin
                n_x   = a_x - (a_y >>> k);
                n_y   = a_y + (a_x >>> k);
                n_ang = a_ang - ATAN_K;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_reached[k] <= a_r;
                r_x[k]       <= n_x;
                r_y[k]       <= n_y;
                r_xrot[k]    <= a_xrot;
                r_ang[k]     <= n_ang;
            end
        end
    end

    assign o_ctl   = '{valid: r_valid[N-1], reached: r_reached[N-1]};
    assign o_x_rot = r_xrot[N-1];
    assign o_ang   = r_ang[N-1];

endmodule

/* rtl/core/ggvc_cmd.sv */
// ============================================================================
// ggvc_cmd
// Command scaling: 1/K and radian conversion, gains, rounding, saturation
// and the arrival override (four stages).
// ============================================================================
`timescale 1ns / 1ps

module ggvc_cmd (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  ggvc_pkg::t_ctl                       i_ctl,
    input  logic signed [ggvc_pkg::VEC_W-1:0]    i_x_rot,
    input  logic        [ggvc_pkg::ANG_W-1:0]    i_ang,
    input  logic        [ggvc_pkg::GAIN_W-1:0]   i_linear_gain,
    input  logic        [ggvc_pkg::GAIN_W-1:0]   i_turn_gain,
    output logic                                 o_valid,
    output ggvc_pkg::t_result                    o_res
);

    localparam int PP_W  = 49;   // partial products
    localparam int SUM_W = 66;   // recombined products
    localparam int TX_W  = 33;
    localparam int RAD_W = 32;
    localparam int LP_W  = 46;
    localparam int TP_W  = 45;
    localparam int LIN_W = LP_W - 22;

    localparam logic [ggvc_pkg::ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    function automatic logic signed [ggvc_pkg::CMD_W-1:0] sat16(
        input logic signed [LIN_W-1:0] v
    );
        logic signed [ggvc_pkg::CMD_W-1:0] r;
        if (v > 24'sd32767)       r = 16'sd32767;
        else if (v < -24'sd32768) r = -16'sd32768;
        else                      r = v[ggvc_pkg::CMD_W-1:0];
        return r;
    endfunction

    logic                    r_v1, r_v2, r_v3;
    logic                    r_rch1, r_rch2, r_rch3;
    logic signed [PP_W-1:0]  r_px_hi, r_px_lo, r_pz_hi, r_pz_lo;
    logic signed [TX_W-1:0]  r_tx;
    logic signed [RAD_W-1:0] r_rad;
    logic signed [LP_W-1:0]  r_lp;
    logic signed [TP_W-1:0]  r_tp;
    logic                    r_valid;
    ggvc_pkg::t_result       r_res;

    logic signed [32:0]      z33;
    logic signed [PP_W-1:0]  n_px_hi, n_px_lo, n_pz_hi, n_pz_lo;
    logic signed [SUM_W-1:0] sum_x, sum_z;
    logic signed [LP_W-1:0]  lin_sum;
    logic signed [TP_W-1:0]  trn_sum;
    logic signed [ggvc_pkg::CMD_W-1:0] lin_sat, trn_sat;

    // stage 1: split products (x by 1/K, angle by pi)
    always_comb begin
        if (i_ang == HALF_TURN) z33 = 33'sd2147483648;   // half turn counts as +pi
        else                    z33 = $signed({i_ang[ggvc_pkg::ANG_W-1], i_ang});
        n_px_hi = $signed(i_x_rot[ggvc_pkg::VEC_W-1:17]) * ggvc_pkg::INV_GAIN_Q30;
        n_px_lo = $signed({1'b0, i_x_rot[16:0]}) * ggvc_pkg::INV_GAIN_Q30;
        n_pz_hi = $signed(z33[32:16]) * ggvc_pkg::PI_Q29;
        n_pz_lo = $signed({1'b0, z33[15:0]}) * ggvc_pkg::PI_Q29;
    end

    // stage 2: recombine with rounding
    assign sum_x = (SUM_W'(r_px_hi) <<< 17) + SUM_W'(r_px_lo) + (SUM_W'(1) <<< 29);
    assign sum_z = (SUM_W'(r_pz_hi) <<< 16) + SUM_W'(r_pz_lo) + (SUM_W'(1) <<< 31);

    // stage 4: round, saturate
    assign lin_sum = r_lp + (LP_W'(1) <<< 21);
    assign trn_sum = r_tp + (TP_W'(1) <<< 23);
    assign lin_sat = sat16(lin_sum[LP_W-1:22]);
    assign trn_sat = sat16(LIN_W'($signed(trn_sum[TP_W-1:24])));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_ctl.valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rch1  <= i_ctl.reached;
            r_px_hi <= n_px_hi;
            r_px_lo <= n_px_lo;
            r_pz_hi <= n_pz_hi;
            r_pz_lo <= n_pz_lo;

            r_rch2  <= r_rch1;
            r_tx    <= sum_x[TX_W+29:30];
            r_rad   <= sum_z[RAD_W+31:32];

            r_rch3  <= r_rch2;
            r_lp    <= $signed({1'b0, i_linear_gain}) * r_tx;
            r_tp    <= $signed({1'b0, i_turn_gain}) * r_rad;

            r_res.reached <= r_rch3;
            if (r_rch3) begin
                r_res.linear_speed <= '0;
                r_res.turn_rate    <= '0;
            end else begin
                r_res.linear_speed <= lin_sat;
                // zero forward gain means a zero vector: no turn either
                r_res.turn_rate    <= (i_linear_gain == '0) ? '0 : trn_sat;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/core/go_to_goal_velocity_controller_top.sv */
// ============================================================================
// go_to_goal_velocity_controller_top
// Proportional go-to-goal controller for a unicycle robot: pose and goal in,
// arrival flag, forward speed and turn rate out.
// ============================================================================
//
//  Channel  | Dir | Signals                       | Contents
//  ---------+-----+-------------------------------+------------------------------
//  s_axis   | in  | tvalid / tready / tdata[79:0] | pose and goal, one per transaction
//  m_axis   | out | tvalid / tready / tdata[31:0] | speed commands, tuser = reached
//  cfg      | in  | wr_en / index / data[15:0]    | gains and arrival tolerance
//
//  Throughput: one transaction per clock in each direction while m_axis tready
//  stays high. Pipeline from s_axis acceptance to m_axis valid: 3 front,
//  NUM_ITER rotation, 1 + NUM_ITER vectoring, 4 scaling and 1 output
//  register stage.
//  Stalls: the whole pipeline advances together; an output register plus a
//  skid register absorb the first stalled result, so s_axis tready depends
//  only on registered state. No state carries between transactions.
//  Reset: synchronous, active low; clears valid bits and loads register
//  defaults. No clearing pass.
//
`timescale 1ns / 1ps

module go_to_goal_velocity_controller_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] heading, [63:48] goal_x, [79:64] goal_y
    input  logic [5*ggvc_pkg::POS_W-1:0]          i_s_axis_tdata,
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [15:0] linear_speed, [31:16] turn_rate
    output logic [2*ggvc_pkg::CMD_W-1:0]          o_m_axis_tdata,
    // [0] reached
    output logic [0:0]                            o_m_axis_tuser,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [ggvc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ggvc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ggvc_pkg::GAIN_W-1:0] r_linear_gain;
    logic [ggvc_pkg::GAIN_W-1:0] r_turn_gain;
    logic [ggvc_pkg::TOL_W-1:0]  r_arrival_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear_gain <= ggvc_pkg::LINEAR_GAIN_RST;
            r_turn_gain   <= ggvc_pkg::TURN_GAIN_RST;
            r_arrival_tol <= ggvc_pkg::ARRIVAL_TOL_RST;
        end else if (i_cfg_wr_en) begin
            unique case (ggvc_pkg::t_cfg_idx'(i_cfg_index))
                ggvc_pkg::CFG_LINEAR_GAIN: r_linear_gain <= i_cfg_data[ggvc_pkg::GAIN_W-1:0];
                ggvc_pkg::CFG_TURN_GAIN:   r_turn_gain   <= i_cfg_data[ggvc_pkg::GAIN_W-1:0];
                ggvc_pkg::CFG_ARRIVAL_TOL: r_arrival_tol <= i_cfg_data;
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline enable: frozen only while the skid register holds a result
    // ------------------------------------------------------------------
    logic              r_out_valid, r_skid_valid;
    ggvc_pkg::t_result r_out, r_skid;
    logic              pipe_en;

    assign pipe_en         = !r_skid_valid;
    assign o_s_axis_tready = pipe_en;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    ggvc_pkg::t_ctl                     front_ctl, rot_ctl, vec_ctl;
    logic signed [ggvc_pkg::VEC_W-1:0]  front_x, front_y, rot_x, rot_y, vec_xrot;
    logic signed [ggvc_pkg::ROT_ZW-1:0] front_z;
    logic        [ggvc_pkg::ANG_W-1:0]  vec_ang;
    logic                               cmd_valid;
    ggvc_pkg::t_result                  cmd_res;

    // error, squared distance vs tolerance, fold heading into +/- pi/2
    ggvc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (i_s_axis_tvalid),
        .i_pos_x   ($signed(i_s_axis_tdata[15:0])),
        .i_pos_y   ($signed(i_s_axis_tdata[31:16])),
        .i_heading ($signed(i_s_axis_tdata[47:32])),
        .i_goal_x  ($signed(i_s_axis_tdata[63:48])),
        .i_goal_y  ($signed(i_s_axis_tdata[79:64])),
        .i_tol     (r_arrival_tol),
        .o_ctl     (front_ctl),
        .o_x       (front_x),
        .o_y       (front_y),
        .o_z       (front_z)
    );

    // world-frame error rotated by -heading (gain K left in)
    ggvc_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_ctl   (front_ctl),
        .i_x     (front_x),
        .i_y     (front_y),
        .i_z     (front_z),
        .o_ctl   (rot_ctl),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    // heading error = atan2(body y, body x)
    ggvc_vector u_vector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_ctl   (rot_ctl),
        .i_x     (rot_x),
        .i_y     (rot_y),
        .o_ctl   (vec_ctl),
        .o_x_rot (vec_xrot),
        .o_ang   (vec_ang)
    );

    // gains, rounding, saturation
    ggvc_cmd u_cmd (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (pipe_en),
        .i_ctl         (vec_ctl),
        .i_x_rot       (vec_xrot),
        .i_ang         (vec_ang),
        .i_linear_gain (r_linear_gain),
        .i_turn_gain   (r_turn_gain),
        .o_valid       (cmd_valid),
        .o_res         (cmd_res)
    );

    // ------------------------------------------------------------------
    // output register + skid register
    // ------------------------------------------------------------------
    logic              n_out_valid, n_skid_valid;
    ggvc_pkg::t_result n_out, n_skid;
    logic              take, push;

    assign take = r_out_valid && i_m_axis_tready;
    assign push = pipe_en && cmd_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take) begin
            n_out_valid = 1'b0;
        end
        if (r_skid_valid) begin
            // pipeline frozen; drain skid into the output register
            if (take) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || take) begin
                n_out       = cmd_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = cmd_res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.turn_rate, r_out.linear_speed};
    assign o_m_axis_tuser  = r_out.reached;

endmodule

/* rtl/core/ggvc_checker.sv */
// ============================================================================
// ggvc_checker
// Port-level checks on the go-to-goal controller, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps

module ggvc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [2*ggvc_pkg::CMD_W-1:0]      o_m_axis_tdata,
    input logic [0:0]                        o_m_axis_tuser
);

    // an arrived result carries zero commands
    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("reached result with nonzero speed");

    // input only held off while a result is waiting at the output
    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled output changed");

endmodule

bind go_to_goal_velocity_controller_top ggvc_checker u_ggvc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

/* verif/ggvc_command_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// ggvc_command_checker
// Watches the pose and command channels of the go-to-goal controller, keeps
// a copy of its gain and tolerance registers, predicts every speed command
// and compares it with what the block sends.
// ============================================================================

module ggvc_command_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pose_valid,
    input  logic        i_pose_ready,
    input  logic [79:0] i_pose_data,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [31:0] i_cmd_data,
    input  logic [0:0]  i_cmd_user,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [11:0] LIN_GAIN_DEFAULT  = 12'd512;
    localparam logic [11:0] TURN_GAIN_DEFAULT = 12'd512;
    localparam logic [15:0] TOL_DEFAULT       = 16'd3;

    localparam longint INV_K_Q30   = 64'sd652032874;
    localparam longint PI_Q29      = 64'sd1686629713;
    localparam longint QUARTER_BAM = 64'sd1 << 30;
    localparam longint HALF_BAM    = 64'sd1 << 31;

    // atan(2^-i), binary angle with 2^31 = pi
    logic [31:0] atan_bam [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic [11:0] lin_gain_q;
    logic [11:0] turn_gain_q;
    logic [15:0] tol_q;

    ggvc_pkg::t_result cmd_expected_q[$];
    int                mismatch_cnt = 0;

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic ggvc_pkg::t_result predict_command(input logic [79:0] pose);
        longint            dx, dy, hd, x, y, z, t, tx, lin, rad, turn;
        logic [31:0]       ang;
        ggvc_pkg::t_result r;
        dx = longint'($signed(pose[63:48])) - longint'($signed(pose[15:0]));
        dy = longint'($signed(pose[79:64])) - longint'($signed(pose[31:16]));
        hd = longint'($signed(pose[47:32]));
        r  = '0;
        if (dx * dx + dy * dy <= longint'(tol_q) * longint'(tol_q)) begin
            r.reached = 1'b1;
            return r;
        end

        // rotate the world-frame error by -heading, folding into +-pi/2 first
        x = dx * 16384;
        y = dy * 16384;
        z = -(hd * 65536);
        if (z > QUARTER_BAM) begin
            z = z - HALF_BAM;
            x = -x;
            y = -y;
        end else if (z < -QUARTER_BAM) begin
            z = z + HALF_BAM;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ggvc_pkg::NUM_ITER; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z = z - longint'(atan_bam[i]);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z = z + longint'(atan_bam[i]);
            end
        end
        tx  = (x * INV_K_Q30 + (64'sd1 << 29)) >>> 30;
        lin = (longint'(lin_gain_q) * tx + (64'sd1 << 21)) >>> 22;

        // angle of the body-frame error, still in CORDIC gain units
        ang = '0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            ang = 32'h80000000;
        end
        for (int i = 0; i < ggvc_pkg::NUM_ITER; i++) begin
            if (y >= 0) begin
                t   = x + (y >>> i);
                y   = y - (x >>> i);
                x   = t;
                ang = ang + atan_bam[i];
            end else begin
                t   = x - (y >>> i);
                y   = y + (x >>> i);
                x   = t;
                ang = ang - atan_bam[i];
            end
        end
        z = longint'($signed(ang));
        if (z == -HALF_BAM)
            z = HALF_BAM;       // straight behind counts as +pi
        rad  = (z * PI_Q29 + (64'sd1 << 31)) >>> 32;
        turn = (longint'(turn_gain_q) * rad + (64'sd1 << 23)) >>> 24;
        if (lin_gain_q == '0)
            turn = 0;

        r.linear_speed = clamp16(lin);
        r.turn_rate    = clamp16(turn);
        return r;
    endfunction

    // register mirror; unmapped indexes are dropped
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lin_gain_q  <= LIN_GAIN_DEFAULT;
            turn_gain_q <= TURN_GAIN_DEFAULT;
            tol_q       <= TOL_DEFAULT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ggvc_pkg::CFG_LINEAR_GAIN: lin_gain_q  <= i_cfg_data[11:0];
                ggvc_pkg::CFG_TURN_GAIN:   turn_gain_q <= i_cfg_data[11:0];
                ggvc_pkg::CFG_ARRIVAL_TOL: tol_q       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        ggvc_pkg::t_result want;
        if (i_rst_n) begin
            if (i_cmd_valid && i_cmd_ready) begin
                if (cmd_expected_q.size() == 0) begin
                    $display("%0t: command with none pending: reached %0d lin %0d turn %0d",
                             $time, i_cmd_user[0], $signed(i_cmd_data[15:0]),
                             $signed(i_cmd_data[31:16]));
                    mismatch_cnt++;
                end else begin
                    want = cmd_expected_q.pop_front();
                    if (i_cmd_user[0] !== want.reached) begin
                        $display("%0t: reached expected %0d actual %0d",
                                 $time, want.reached, i_cmd_user[0]);
                        mismatch_cnt++;
                    end
                    if (i_cmd_data[15:0] !== want.linear_speed) begin
                        $display("%0t: linear_speed expected %0d actual %0d",
                                 $time, want.linear_speed, $signed(i_cmd_data[15:0]));
                        mismatch_cnt++;
                    end
                    if (i_cmd_data[31:16] !== want.turn_rate) begin
                        $display("%0t: turn_rate expected %0d actual %0d",
                                 $time, want.turn_rate, $signed(i_cmd_data[31:16]));
                        mismatch_cnt++;
                    end
                end
            end
            if (i_pose_valid && i_pose_ready)
                cmd_expected_q.push_back(predict_command(i_pose_data));
        end
        o_pending    <= cmd_expected_q.size();
        o_fail_count <= mismatch_cnt;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench for the go-to-goal velocity controller: drives poses and goals
// into the input stream and register writes into the config port, with
// random idling on both streams; a separate checker predicts and compares
// every speed command.
// ============================================================================

module tb;

    localparam int          CLK_HALF     = 10;          // 20 ns period
    localparam int          CYCLE_LIMIT  = 400000;      // generous run limit
    localparam int          DRAIN_CYCLES = 60;          // longer than the pipeline latency
    localparam int          HOLD_CYCLES  = 400;         // long receiver hold-off
    localparam int          SEG_ITEMS    = 300;         // random items per config segment
    localparam logic [1:0]  CFG_UNMAPPED = 2'd3;        // index with no register behind it

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;

    // input stream: pose and goal
    logic        pose_valid = 1'b0;
    logic        pose_ready;
    logic [79:0] pose_data  = '0;

    // output stream: speed commands
    logic        cmd_valid;
    logic        cmd_ready  = 1'b0;
    logic [31:0] cmd_data;
    logic [0:0]  cmd_user;

    // config write port
    logic        cfg_wr_en  = 1'b0;
    logic [1:0]  cfg_index  = '0;
    logic [15:0] cfg_data   = '0;

    int          mismatches;
    int          cmds_pending;

    // idling percentages per side, and what the stimulus believes the tolerance is
    int          src_idle_pct = 0;
    int          dst_idle_pct = 0;
    int          tol_cur      = 3;

    int          cycle_cnt    = 0;
    int          poses_taken  = 0;
    int          hold_left    = 0;
    int          holds_done   = 0;

    go_to_goal_velocity_controller_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (pose_valid),
        .o_s_axis_tready (pose_ready),
        .i_s_axis_tdata  (pose_data),
        .o_m_axis_tvalid (cmd_valid),
        .i_m_axis_tready (cmd_ready),
        .o_m_axis_tdata  (cmd_data),
        .o_m_axis_tuser  (cmd_user),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    ggvc_command_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pose_valid (pose_valid),
        .i_pose_ready (pose_ready),
        .i_pose_data  (pose_data),
        .i_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .i_cmd_data   (cmd_data),
        .i_cmd_user   (cmd_user),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (mismatches),
        .o_pending    (cmds_pending)
    );

    initial begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Run limit. Slowest sane run is roughly 1800 transactions under heavy
    // receiver idling, plus two long hold-offs and settle gaps; the limit is
    // many times that.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d commands outstanding", $time, cmds_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && pose_valid && pose_ready)
            poses_taken <= poses_taken + 1;
    end

    // ------------------------------------------------------------------------
    // Receiver. Random tready per the current idle percentage, except for two
    // long hold-offs (early on, and again while the sender runs flat out) that
    // let the pipeline back up until the input side stalls.
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            cmd_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if ((holds_done == 0 && poses_taken >= 100) ||
                     (holds_done == 1 && poses_taken >= 1650)) begin
            cmd_ready <= 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            holds_done = holds_done + 1;
        end else begin
            cmd_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All of them start and end just after a falling edge.
    // send_pose leaves tvalid high, so whatever comes next must drive it in
    // the same step.
    // ------------------------------------------------------------------------
    task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                             input logic [15:0] hd, input logic [15:0] gx,
                             input logic [15:0] gy);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            pose_valid <= 1'b0;
            @(negedge clk);
        end
        pose_valid <= 1'b1;
        pose_data  <= {gy, gx, hd, py, px};
        @(posedge clk);
        while (!pose_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop tvalid and wait until every command has come back
    task automatic settle();
        pose_valid <= 1'b0;
        while (cmds_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // empties the pipeline before writing the registers
    task automatic apply_cfg(input logic [15:0] lin_g, input logic [15:0] turn_g,
                             input logic [15:0] tol);
        settle();
        write_reg(ggvc_pkg::CFG_LINEAR_GAIN, lin_g);
        write_reg(ggvc_pkg::CFG_TURN_GAIN, turn_g);
        write_reg(ggvc_pkg::CFG_ARRIVAL_TOL, tol);
        tol_cur = int'(tol);
    endtask

    // ------------------------------------------------------------------------
    // Random poses: half fully random, the rest aimed at the tolerance edge,
    // at the heading fold points, at axis-aligned errors and at the largest
    // errors the 17-bit difference can hold.
    // ------------------------------------------------------------------------
    task automatic send_random_pose();
        logic [15:0] px, py, hd, gx, gy;
        int          span;
        px   = 16'($urandom());
        py   = 16'($urandom());
        hd   = 16'($urandom());
        gx   = 16'($urandom());
        gy   = 16'($urandom());
        span = (tol_cur > 1000) ? tol_cur / 2 : tol_cur + 4;
        case ($urandom_range(0, 9))
            5, 6: begin
                // error close to the arrival radius
                gx = 16'(px + $urandom_range(0, 2 * span) - span);
                gy = 16'(py + $urandom_range(0, 2 * span) - span);
            end
            7: begin
                // headings at +-pi/2 and pi, where the rotation folds
                case ($urandom_range(0, 5))
                    0: hd = 16'sd16384;
                    1: hd = -16'sd16384;
                    2: hd = 16'h8000;
                    3: hd = 16'sd32767;
                    4: hd = 16'sd16383;
                    default: hd = -16'sd16385;
                endcase
            end
            8: begin
                if ($urandom_range(0, 1))
                    gy = py;
                else
                    gx = px;
            end
            9: begin
                // opposite corners of the field
                px[15:12] = 4'h8;
                gx[15:12] = 4'h7;
                if ($urandom_range(0, 1)) begin
                    py[15:12] = 4'h7;
                    gy[15:12] = 4'h8;
                end
            end
            default: ;
        endcase
        send_pose(px, py, hd, gx, gy);
    endtask

    task automatic set_idle(input int src_pct, input int dst_pct);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed, register defaults: gains 2.0, tolerance 3 ----
        set_idle(26, 77);
        send_pose(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);              // zero error
        send_pose(16'd0, 16'd0, 16'd0, 16'd3, 16'd0);              // exactly on the radius
        send_pose(16'd0, 16'd0, 16'd0, 16'd3, 16'd1);              // just outside
        send_pose(16'h8000, 16'h8000, 16'd0, 16'h7FFF, 16'h7FFF);  // largest error
        send_pose(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
        send_pose(16'd0, 16'd0, 16'h7FFF, 16'd256, 16'd0);
        send_pose(16'd0, 16'd0, 16'd0, -16'sd256, 16'd0);          // goal straight behind
        send_pose(16'd0, 16'd0, 16'sd16384, 16'd0, 16'd256);
        send_pose(16'd0, 16'd0, -16'sd16384, 16'd256, 16'd256);
        send_pose(16'd0, 16'd0, 16'h8000, -16'sd512, 16'd100);
        send_pose(16'd100, -16'sd200, 16'd12345, 16'd100, -16'sd199);

        // ---- zero linear gain, zero tolerance ----
        apply_cfg(16'd0, 16'd4095, 16'd0);
        send_pose(16'd1234, -16'sd77, 16'd999, 16'd1234, -16'sd77);
        send_pose(16'd1234, -16'sd77, 16'd999, 16'd1235, -16'sd77);
        send_pose(16'd0, 16'd0, 16'd3000, 16'd5000, -16'sd7000);

        // ---- full-scale gains, widest tolerance; upper bits of the gains are
        //      dropped by the register, and the unmapped index is ignored ----
        apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_UNMAPPED, 16'h0001);
        send_pose(16'h8000, 16'd0, 16'd0, 16'h7FFF, 16'd0);        // on the radius
        send_pose(16'h8000, 16'd0, 16'd0, 16'h7FFF, 16'd1);        // saturating speed
        send_pose(16'h8000, 16'h8000, 16'd500, 16'h7FFF, 16'h7FFF);
        send_pose(16'h7FFF, 16'd50, 16'd0, 16'h8000, -16'sd50);    // saturating turn

        // ---- smallest nonzero gains, moderate tolerance ----
        apply_cfg(16'd1, 16'd1, 16'd300);
        send_pose(16'd0, 16'd0, 16'd0, 16'd200, 16'd200);
        send_pose(16'd0, 16'd0, -16'sd5000, 16'd400, 16'd0);

        // ---- random segments, one register setting each ----
        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: apply_cfg(16'd512, 16'd512, 16'd3);
                1: apply_cfg(16'd4095, 16'd4095, 16'd0);
                2: apply_cfg(16'd0, 16'($urandom_range(0, 4095)),
                             16'($urandom_range(0, 500)));
                3: apply_cfg(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                             16'($urandom_range(0, 65535)));
                4: apply_cfg(16'd1, 16'd4095, 16'd65535);
                default: apply_cfg(16'($urandom_range(0, 4095)), 16'd1,
                                   16'($urandom_range(0, 40)));
            endcase
            // receiver-idle then sender-idle heavy, then back to back
            if (seg < 2)
                set_idle(26, 77);
            else if (seg < 4)
                set_idle(77, 26);
            else
                set_idle(0, 0);
            repeat (SEG_ITEMS) send_random_pose();
        end

        // ---- drain and report ----
        pose_valid <= 1'b0;
        for (int w = 0; w < 20000 && cmds_pending != 0; w++)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (cmds_pending != 0)
            $display("%0t: %0d commands never arrived", $time, cmds_pending);
        if (mismatches == 0 && cmds_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
